// File: hdl/kpsd_pkg.sv
// Shared types and constants for the keypad scanner with debounce and auto-repeat.
// No dependencies; used by kpsd_core and keypad_scan_debounce_repeat.
package kpsd_pkg;

  localparam logic [4:0] NO_KEY     = 5'd16;
  localparam logic [4:0] ROW_STRIDE = 5'd4;
  localparam logic [2:0] LAST_STAGE = 3'd6;
  localparam int unsigned NUM_WAITS = 6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TARGET = 3'd0,
    REG_HOLD_WAIT_0     = 3'd1,
    REG_HOLD_WAIT_1     = 3'd2,
    REG_HOLD_WAIT_2     = 3'd3,
    REG_HOLD_WAIT_3     = 3'd4,
    REG_HOLD_WAIT_4     = 3'd5,
    REG_HOLD_WAIT_5     = 3'd6,
    REG_UNUSED          = 3'd7
  } cfg_reg_t;

  localparam logic [7:0]  DEBOUNCE_RESET  = 8'd5;
  localparam logic [15:0] HOLD_WAIT_RESET = 16'd50;

  // One result beat, last field in the lowest bits
  typedef struct packed {
    logic [2:0] repeat_stage;
    logic       new_press;
    logic [4:0] held_key_code;
    logic [1:0] drive_column;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// File: hdl/kpsd_core.sv
// Scan state, debounce counter, hold/repeat staging and configuration registers.
// Depends on kpsd_pkg. Produces the result of the current tick combinationally.
module kpsd_core #(
  parameter int NUM_COLUMNS = 4,
  parameter int NUM_ROWS    = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [3:0]                         row_bits,
  input  logic                               cfg_we,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output kpsd_pkg::result_t                  result
);

  logic [7:0]  debounce_target;
  logic [15:0] hold_wait [kpsd_pkg::NUM_WAITS];

  logic [1:0]  scan_column, scan_column_next;
  logic [4:0]  last_code, last_code_next;
  logic [7:0]  match_count, match_count_next;
  logic [4:0]  held_code, held_code_next;
  logic [15:0] hold_count, hold_count_next;
  logic [2:0]  stage, stage_next;
  logic        press;

  logic        row_found;
  logic [1:0]  row_sel;
  logic [4:0]  code;
  logic [7:0]  match_inc;
  logic [15:0] hold_inc;
  logic [15:0] stage_wait;

  // Highest active row among those wired up
  always_comb begin
    row_found = 1'b0;
    row_sel   = 2'd0;
    for (int r = 0; r < 4; r++) begin
      if (r < NUM_ROWS && row_bits[r]) begin
        row_found = 1'b1;
        row_sel   = 2'(r);
      end
    end
  end

  assign code       = {3'd0, scan_column} + (kpsd_pkg::ROW_STRIDE * {3'd0, row_sel});
  assign match_inc  = match_count + 8'd1;
  assign hold_inc   = (hold_count == 16'hFFFF) ? hold_count : hold_count + 16'd1;
  assign stage_wait = (stage < kpsd_pkg::LAST_STAGE) ? hold_wait[stage] : 16'd0;

  always_comb begin
    scan_column_next = scan_column;
    last_code_next   = last_code;
    match_count_next = match_count;
    held_code_next   = held_code;
    hold_count_next  = hold_count;
    stage_next       = stage;
    press            = 1'b0;
    if (row_found) begin
      if (code == last_code) begin
        match_count_next = match_inc;
        if (match_inc == debounce_target) begin
          match_count_next = 8'd0;
          if (held_code == kpsd_pkg::NO_KEY) begin
            held_code_next  = last_code;
            press           = 1'b1;
            hold_count_next = 16'd0;
            stage_next      = 3'd0;
          end else begin
            hold_count_next = hold_inc;
            if (stage < kpsd_pkg::LAST_STAGE && hold_inc >= stage_wait) begin
              hold_count_next = 16'd0;
              stage_next      = stage + 3'd1;
            end
          end
        end
      end else begin
        // new code: count is kept, this scan is not a match
        last_code_next = code;
      end
    end else begin
      held_code_next   = kpsd_pkg::NO_KEY;
      scan_column_next = (scan_column == 2'(NUM_COLUMNS - 1)) ? 2'd0 : scan_column + 2'd1;
      hold_count_next  = 16'd0;
      stage_next       = 3'd0;
    end
  end

  assign result.drive_column  = scan_column_next;
  assign result.held_key_code = held_code_next;
  assign result.new_press     = press;
  assign result.repeat_stage  = stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= 2'd0;
      last_code   <= kpsd_pkg::NO_KEY;
      match_count <= 8'd0;
      held_code   <= kpsd_pkg::NO_KEY;
      hold_count  <= 16'd0;
      stage       <= 3'd0;
    end else if (step) begin
      scan_column <= scan_column_next;
      last_code   <= last_code_next;
      match_count <= match_count_next;
      held_code   <= held_code_next;
      hold_count  <= hold_count_next;
      stage       <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_target <= kpsd_pkg::DEBOUNCE_RESET;
      for (int i = 0; i < kpsd_pkg::NUM_WAITS; i++) begin
        hold_wait[i] <= kpsd_pkg::HOLD_WAIT_RESET;
      end
    end else if (cfg_we) begin
      unique case (kpsd_pkg::cfg_reg_t'(cfg_index))
        kpsd_pkg::REG_DEBOUNCE_TARGET: debounce_target <= cfg_data[7:0];
        kpsd_pkg::REG_HOLD_WAIT_0:     hold_wait[0] <= cfg_data;
        kpsd_pkg::REG_HOLD_WAIT_1:     hold_wait[1] <= cfg_data;
        kpsd_pkg::REG_HOLD_WAIT_2:     hold_wait[2] <= cfg_data;
        kpsd_pkg::REG_HOLD_WAIT_3:     hold_wait[3] <= cfg_data;
        kpsd_pkg::REG_HOLD_WAIT_4:     hold_wait[4] <= cfg_data;
        kpsd_pkg::REG_HOLD_WAIT_5:     hold_wait[5] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/keypad_scan_debounce_repeat.sv
// Top level: 4x4 matrix keypad scanner with debounce and staged auto-repeat.
// Depends on kpsd_pkg and kpsd_core; adds the output register and skid stage.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tdata[3:0]  row_bits
//   m_*       out   m_tvalid / m_tready    m_tdata[10:0] column, key, press, stage
//   cfg_*     in    cfg_we (no wait)       cfg_index, cfg_data
//
// One beat per cycle while s_tready is high; each scan tick is resolved in the cycle it is taken and
// its result is registered in the output register (via the skid register if the output stalls) for m_*.
// rst is synchronous: state and config return to defaults, both buffers empty.
// A stalled output holds in the output register; one more beat lands in the
// skid register, and s_tready drops only while the skid register is full.
module keypad_scan_debounce_repeat #(
  parameter int NUM_COLUMNS = 4,
  parameter int NUM_ROWS    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [3:0] row_bits
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [1:0] drive_column, [6:2] held_key_code,
                                                     // [7] new_press, [10:8] repeat_stage
  input  logic                            cfg_we,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              s_fire;
  logic              m_fire;
  kpsd_pkg::result_t core_result;
  kpsd_pkg::result_t out_q;
  kpsd_pkg::result_t skid_q;
  logic              out_valid;
  logic              skid_valid;

  assign s_tready = !skid_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = out_valid && m_tready;

  kpsd_core #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s_fire),
    .row_bits  (s_tdata[3:0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s_fire;
      end
    end else if (s_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || m_fire) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (s_fire) begin
        out_q <= core_result;
      end
    end else if (s_fire) begin
      skid_q <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(16 - kpsd_pkg::RESULT_W)'(0), out_q};

endmodule
